// ===== hdl/dme_pkg.sv =====
// ----------------------------------------------------------------------------
// dme_pkg
// Shared types, constants and the command table for the delta move encoder.
// ----------------------------------------------------------------------------
package dme_pkg;

    localparam int COORD_W  = 15;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 12;
    localparam int DIGIT_W  = 5;    // radix 32
    localparam int MOVE_MAX = 7;    // command + up to six digits
    localparam int LEN_W    = 3;
    localparam int IDX_W    = 5;    // covers a full word list with flush

    // configuration register indexes
    localparam logic REG_CHAR_BIAS    = 1'b0;
    localparam logic REG_BUFFER_LIMIT = 1'b1;

    localparam logic [BYTE_W-1:0]  CHAR_BIAS_RST    = 8'd32;
    localparam logic [COUNT_W-1:0] BUFFER_LIMIT_RST = 12'd128;
    localparam logic [COUNT_W-1:0] COUNT_RST        = 12'd2;

    // flush sequence: ETX, spaces, STX, space
    localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'h03;
    localparam logic [BYTE_W-1:0] STX_BYTE   = 8'h02;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [IDX_W-1:0]  FLUSH_SPACES = 5'd20;
    localparam logic [IDX_W-1:0]  FLUSH_LEN    = 5'd23;

    // row = 3 - signed y digit count, column = 3 + signed x digit count
    localparam logic [5:0] MOVE_CMD_TABLE [7][7] = '{
        '{6'd17, 6'd41, 6'd45, 6'd28, 6'd44, 6'd40, 6'd16},
        '{6'd49, 6'd21, 6'd57, 6'd32, 6'd56, 6'd20, 6'd48},
        '{6'd53, 6'd61, 6'd25, 6'd36, 6'd24, 6'd60, 6'd52},
        '{6'd29, 6'd33, 6'd37, 6'd0,  6'd38, 6'd34, 6'd30},
        '{6'd55, 6'd63, 6'd27, 6'd39, 6'd26, 6'd62, 6'd54},
        '{6'd51, 6'd23, 6'd59, 6'd35, 6'd58, 6'd22, 6'd50},
        '{6'd19, 6'd43, 6'd47, 6'd31, 6'd46, 6'd42, 6'd18}
    };

    // one decoded move: command and digit bytes, already biased
    typedef struct packed {
        logic [MOVE_MAX-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                len;
        logic                            flush;
        logic                            zero;
    } dme_move_t;

endpackage

// ===== hdl/dme_decode.sv =====
// ----------------------------------------------------------------------------
// dme_decode
// Deltas, base-32 digits, command lookup and byte count update for one move.
// ----------------------------------------------------------------------------
module dme_decode
    import dme_pkg::*;
(
    input  logic [COORD_W-1:0] from_x,
    input  logic [COORD_W-1:0] from_y,
    input  logic [COORD_W-1:0] to_x,
    input  logic [COORD_W-1:0] to_y,
    input  logic [BYTE_W-1:0]  char_bias,
    input  logic [COUNT_W-1:0] buffer_limit,
    input  logic [COUNT_W-1:0] byte_count,
    output dme_move_t          move,
    output logic [COUNT_W-1:0] count_next
);

    logic               xneg, yneg;
    logic [COORD_W-1:0] mag_x, mag_y;
    logic [1:0]         xc, yc;
    logic [2:0][BYTE_W-1:0] xd, yd;
    logic [2:0]         row, col;
    logic [COUNT_W:0]   sum;

    function automatic logic [1:0] digit_count(input logic [COORD_W-1:0] mag);
        logic [1:0] c;
        if (mag[14:10] != '0) begin
            c = 2'd3;
        end else if (mag[9:5] != '0) begin
            c = 2'd2;
        end else if (mag[4:0] != '0) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

    // digits high first, leading zeros dropped
    function automatic logic [2:0][BYTE_W-1:0] digit_bytes(
        input logic [COORD_W-1:0] mag,
        input logic [1:0]         cnt,
        input logic [BYTE_W-1:0]  bias
    );
        logic [BYTE_W-1:0]      hi, mi, lo;
        logic [2:0][BYTE_W-1:0] d;
        hi = 8'({3'b0, mag[14:10]} + bias);
        mi = 8'({3'b0, mag[9:5]} + bias);
        lo = 8'({3'b0, mag[4:0]} + bias);
        case (cnt)
            2'd3:    d = {lo, mi, hi};
            2'd2:    d = {lo, lo, mi};
            default: d = {lo, lo, lo};
        endcase
        return d;
    endfunction

    assign xneg  = to_x < from_x;
    assign yneg  = to_y < from_y;
    assign mag_x = xneg ? from_x - to_x : to_x - from_x;
    assign mag_y = yneg ? from_y - to_y : to_y - from_y;
    assign xc    = digit_count(mag_x);
    assign yc    = digit_count(mag_y);
    assign xd    = digit_bytes(mag_x, xc, char_bias);
    assign yd    = digit_bytes(mag_y, yc, char_bias);
    assign col   = xneg ? 3'd3 - {1'b0, xc} : 3'd3 + {1'b0, xc};
    assign row   = yneg ? 3'd3 + {1'b0, yc} : 3'd3 - {1'b0, yc};

    always_comb begin
        logic [2:0] j;
        logic [2:0] r;
        move.bytes[0] = 8'({2'b0, MOVE_CMD_TABLE[row][col]} + char_bias);
        for (int k = 1; k < MOVE_MAX; k++) begin
            j = 3'(k - 1);
            r = j - {1'b0, xc};
            if (j < {1'b0, xc}) begin
                move.bytes[k] = xd[j[1:0]];
            end else if (r < 3'd3) begin
                move.bytes[k] = yd[r[1:0]];
            end else begin
                move.bytes[k] = '0;
            end
        end
        move.len  = 3'd1 + {1'b0, xc} + {1'b0, yc};
        move.zero = (mag_x == '0) && (mag_y == '0);
        sum        = {1'b0, byte_count} + 13'(move.len);
        move.flush = sum > {1'b0, buffer_limit};
        count_next = move.flush ? COUNT_RST : sum[COUNT_W-1:0];
    end

endmodule

// ===== hdl/dme_emit.sv =====
// ----------------------------------------------------------------------------
// dme_emit
// Holds one decoded move and sends its bytes, then any flush sequence,
// one word per cycle through the output register while m_ready is high.
// ----------------------------------------------------------------------------
module dme_emit
    import dme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  dme_move_t         move,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last
);

    logic                            b_valid_reg;
    logic [MOVE_MAX-1:0][BYTE_W-1:0] b_bytes_reg;
    logic [LEN_W-1:0]                b_len_reg;
    logic                            b_flush_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            m_valid_reg;
    logic [BYTE_W-1:0]               m_out_byte_reg;
    logic                            m_last_reg;

    logic [IDX_W-1:0]  total, fpos;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_last, out_adv, emit, done;

    assign total = IDX_W'(b_len_reg) + (b_flush_reg ? FLUSH_LEN : '0);
    assign fpos  = idx_reg - IDX_W'(b_len_reg);

    always_comb begin
        if (idx_reg < IDX_W'(b_len_reg)) begin
            cur_byte = b_bytes_reg[idx_reg[LEN_W-1:0]];
        end else if (fpos == '0) begin
            cur_byte = ETX_BYTE;
        end else if (fpos == FLUSH_SPACES + 5'd1) begin
            cur_byte = STX_BYTE;
        end else begin
            cur_byte = SPACE_BYTE;
        end
    end

    assign cur_last = idx_reg == total - 5'd1;
    assign out_adv  = !m_valid_reg || m_ready;
    assign emit     = b_valid_reg && out_adv;
    assign done     = emit && cur_last;
    assign free     = !b_valid_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (load) begin
            b_valid_reg <= 1'b1;
            idx_reg     <= '0;
        end else if (done) begin
            b_valid_reg <= 1'b0;
        end else if (emit) begin
            idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_bytes_reg <= move.bytes;
            b_len_reg   <= move.len;
            b_flush_reg <= move.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_byte_reg <= cur_byte;
            m_last_reg     <= cur_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== hdl/plotter_delta_move_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// plotter_delta_move_encoder_unit
// Turns pen moves into plotter link bytes with periodic buffer flush.
// ----------------------------------------------------------------------------
// A move word is registered, decoded combinationally into a command byte
// plus one to six base-32 digit bytes, and then sent out from the output
// register, followed by the 23-byte flush sequence when the byte count
// passes buffer_limit. A move thus sends 2 to 7 bytes, or 25 to 30 with a
// flush; a zero move sends nothing. The output stage sets the rate: one byte
// per cycle while m_ready is high. The next move is decoded while the last
// byte of the current one is sent, so bytes of consecutive moves follow
// without a gap. A move passes the input register, move buffer and output
// register before its first byte appears. Config writes are always ready.
// ----------------------------------------------------------------------------
module plotter_delta_move_encoder_unit
    import dme_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_from_x,
    input  logic [COORD_W-1:0] s_from_y,
    input  logic [COORD_W-1:0] s_to_x,
    input  logic [COORD_W-1:0] s_to_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_out_byte,
    output logic               m_last
);

    logic [BYTE_W-1:0]  char_bias_reg;
    logic [COUNT_W-1:0] buffer_limit_reg;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic               a_valid_reg;
    logic [COORD_W-1:0] from_x_reg, from_y_reg, to_x_reg, to_y_reg;

    dme_move_t move;
    logic      b_free, a_adv, load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_bias_reg    <= CHAR_BIAS_RST;
            buffer_limit_reg <= BUFFER_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHAR_BIAS:    char_bias_reg    <= cfg_data[BYTE_W-1:0];
                REG_BUFFER_LIMIT: buffer_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign a_adv   = a_valid_reg && b_free;
    assign load    = a_adv && !move.zero;
    assign s_ready = !a_valid_reg || b_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            from_x_reg <= s_from_x;
            from_y_reg <= s_from_y;
            to_x_reg   <= s_to_x;
            to_y_reg   <= s_to_y;
        end
    end

    // count follows each nonzero move in order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= COUNT_RST;
        end else if (load) begin
            byte_count_reg <= byte_count_next;
        end
    end

    dme_decode u_decode (
        .from_x       (from_x_reg),
        .from_y       (from_y_reg),
        .to_x         (to_x_reg),
        .to_y         (to_y_reg),
        .char_bias    (char_bias_reg),
        .buffer_limit (buffer_limit_reg),
        .byte_count   (byte_count_reg),
        .move         (move),
        .count_next   (byte_count_next)
    );

    dme_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .move       (move),
        .free       (b_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

// ===== test/tb_plotter_delta_move_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_plotter_delta_move_encoder_unit
// Self-checking bench for the plotter delta move encoder. Pen moves go in on
// a valid/ready channel. A scoreboard predicts the command, digit and flush
// bytes of each move and checks every output word in order. The bench runs
// through several bias and buffer limit settings, with random stalls on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_plotter_delta_move_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dme_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } link_byte_t;

    // Predicts the link bytes of each move and checks the output words.
    class move_byte_scoreboard;
        link_byte_t        due_q[$];
        logic [BYTE_W-1:0]  bias;
        logic [COUNT_W-1:0] limit;
        logic [COUNT_W-1:0] sent_count;
        int                 errors;

        function new();
            bias       = CHAR_BIAS_RST;
            limit      = BUFFER_LIMIT_RST;
            sent_count = COUNT_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic idx, logic [COUNT_W-1:0] val);
            if (idx == REG_CHAR_BIAS) begin
                bias = val[BYTE_W-1:0];
            end else begin
                limit = val;
            end
        endfunction

        // leading zero digits are dropped, inner zeros are kept
        function int cut_digits(logic [COORD_W-1:0] mag,
                                output logic [2:0][BYTE_W-1:0] dig);
            logic [DIGIT_W-1:0] hi, mi, lo;
            hi  = mag[14:10];
            mi  = mag[9:5];
            lo  = mag[4:0];
            dig = '0;
            if (hi != 0) begin
                dig[0] = bias + hi;
                dig[1] = bias + mi;
                dig[2] = bias + lo;
                return 3;
            end
            if (mi != 0) begin
                dig[0] = bias + mi;
                dig[1] = bias + lo;
                return 2;
            end
            if (lo != 0) begin
                dig[0] = bias + lo;
                return 1;
            end
            return 0;
        endfunction

        function void note_move(logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                                logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
            logic                     xneg, yneg;
            logic [COORD_W-1:0]       mx, my;
            logic [2:0][BYTE_W-1:0]   xd, yd;
            logic [BYTE_W-1:0]        seq[$];
            int                       xc, yc, row, col, total;
            link_byte_t               word;
            xneg = tx < fx;
            yneg = ty < fy;
            mx   = xneg ? fx - tx : tx - fx;
            my   = yneg ? fy - ty : ty - fy;
            if (mx == 0 && my == 0) begin
                return;
            end
            xc  = cut_digits(mx, xd);
            yc  = cut_digits(my, yd);
            col = xneg ? 3 - xc : 3 + xc;
            row = yneg ? 3 + yc : 3 - yc;
            seq.push_back({2'b00, MOVE_CMD_TABLE[row][col]} + bias);
            for (int i = 0; i < xc; i++) begin
                seq.push_back(xd[i]);
            end
            for (int i = 0; i < yc; i++) begin
                seq.push_back(yd[i]);
            end
            // sum is formed as int, so it cannot wrap before the compare
            total = int'(sent_count) + 1 + xc + yc;
            if (total > int'(limit)) begin
                seq.push_back(ETX_BYTE);
                for (int i = 0; i < 20; i++) begin
                    seq.push_back(SPACE_BYTE);
                end
                seq.push_back(STX_BYTE);
                seq.push_back(SPACE_BYTE);
                sent_count = COUNT_RST;
            end else begin
                sent_count = total[COUNT_W-1:0];
            end
            foreach (seq[i]) begin
                word.data = seq[i];
                word.last = (i == seq.size() - 1);
                due_q.push_back(word);
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic last);
            link_byte_t exp_word;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected word, byte %h last %b", $time, data, last);
                errors++;
                return;
            end
            exp_word = due_q.pop_front();
            if (data !== exp_word.data) begin
                $display("%0t: out_byte mismatch, expected %h, got %h",
                         $time, exp_word.data, data);
                errors++;
            end
            if (last !== exp_word.last) begin
                $display("%0t: last mismatch, expected %b, got %b",
                         $time, exp_word.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [COUNT_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [COORD_W-1:0] s_from_x;
    logic [COORD_W-1:0] s_from_y;
    logic [COORD_W-1:0] s_to_x;
    logic [COORD_W-1:0] s_to_y;
    logic               m_valid;
    logic               m_ready;
    logic [BYTE_W-1:0]  m_out_byte;
    logic               m_last;

    move_byte_scoreboard sb = new();

    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic hold_req   = 1'b0;
    int   hold_left  = 0;

    plotter_delta_move_encoder_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_from_x   (s_from_x),
        .s_from_y   (s_from_y),
        .s_to_x     (s_to_x),
        .s_to_y     (s_to_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always #4 aclk = ~aclk;

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(99) < 23) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            sb.check_byte(m_out_byte, m_last);
        end
    end

    // watchdog: ends the run when no word moves on any channel for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("plotter_delta_move_encoder_unit regression: fail");
        $finish;
    end

    // writes both registers back to back, valid stays high between them
    task automatic configure(input logic [COUNT_W-1:0] bias_word,
                             input logic [COUNT_W-1:0] limit_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CHAR_BIAS;
        cfg_data  <= bias_word;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_CHAR_BIAS, bias_word);
        cfg_index <= REG_BUFFER_LIMIT;
        cfg_data  <= limit_word;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_BUFFER_LIMIT, limit_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_move(input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                             input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        if (tx_idle_en) begin
            while ($urandom_range(99) < 23) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_from_x <= fx;
        s_from_y <= fy;
        s_to_x   <= tx;
        s_to_y   <= ty;
        do @(posedge aclk); while (!s_ready);
        sb.note_move(fx, fy, tx, ty);
    endtask

    // one axis with a chosen digit count and sign, placed anywhere in range
    task automatic pick_axis(output logic [COORD_W-1:0] a, output logic [COORD_W-1:0] b);
        int                 n;
        logic [COORD_W-1:0] mag;
        n = $urandom_range(3);
        case (n)
            0: mag = '0;
            1: mag = $urandom_range(31, 1);
            2: mag = $urandom_range(1023, 32);
            default: mag = $urandom_range(32767, 1024);
        endcase
        if ($urandom_range(1)) begin
            a = $urandom_range(32767, mag);
            b = a - mag;
        end else begin
            a = $urandom_range(32767 - mag);
            b = a + mag;
        end
    endtask

    task automatic run_random(input int count);
        logic [COORD_W-1:0] fx, fy, tx, ty;
        int                 pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // zero move
                fx = $urandom_range(32767);
                fy = $urandom_range(32767);
                tx = fx;
                ty = fy;
            end else if (pick < 20) begin
                fx = $urandom_range(32767);
                fy = $urandom_range(32767);
                tx = $urandom_range(32767);
                ty = $urandom_range(32767);
            end else begin
                pick_axis(fx, tx);
                pick_axis(fy, ty);
            end
            send_move(fx, fy, tx, ty);
        end
    endtask

    // register writes only once every expected word is out and the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CHAR_BIAS;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_from_x  <= '0;
        s_from_y  <= '0;
        s_to_x    <= '0;
        s_to_y    <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed moves at reset settings
        send_move(15'd100, 15'd100, 15'd100, 15'd100);
        send_move(15'd0, 15'd0, 15'd0, 15'd0);
        send_move(15'd32767, 15'd32767, 15'd32767, 15'd32767);
        send_move(15'd0, 15'd0, 15'd32767, 15'd0);
        send_move(15'd32767, 15'd0, 15'd0, 15'd0);
        send_move(15'd0, 15'd0, 15'd0, 15'd32767);
        send_move(15'd0, 15'd32767, 15'd0, 15'd0);
        send_move(15'd0, 15'd0, 15'd32767, 15'd32767);
        send_move(15'd32767, 15'd32767, 15'd0, 15'd0);
        send_move(15'd10, 15'd500, 15'd11, 15'd468);
        send_move(15'd500, 15'd7, 15'd469, 15'd8);
        send_move(15'd0, 15'd2000, 15'd1024, 15'd976);
        send_move(15'd300, 15'd300, 15'd332, 15'd300);
        send_move(15'd300, 15'd300, 15'd267, 15'd331);
        send_move(15'd4000, 15'd0, 15'd4000, 15'd1023);
        send_move(15'd20, 15'd20, 15'd25, 15'd15);
        send_move(15'd21000, 15'd100, 15'd20000, 15'd20100);
        send_move(15'd32766, 15'd1, 15'd32767, 15'd0);
        run_random(60);
        drain();

        // limit zero: every nonzero move flushes
        configure(12'h000, 12'd0);
        run_random(30);
        drain();

        // bias wraps, no flush, no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        configure(12'h0FF, 12'd4095);
        run_random(60);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // long output hold-off while moves keep coming; upper data bits ignored for bias
        configure({4'($urandom_range(15)), 8'($urandom_range(255))}, 12'd1);
        hold_req = 1'b1;
        run_random(30);
        drain();

        configure({4'h0, 8'($urandom_range(255))}, 12'($urandom_range(60, 8)));
        run_random(80);
        drain();

        configure({4'($urandom_range(15)), 8'($urandom_range(255))},
                  12'($urandom_range(300, 100)));
        run_random(60);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d words never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("plotter_delta_move_encoder_unit regression: pass");
        end else begin
            $display("plotter_delta_move_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== plotter_delta_move_encoder_unit.f =====
hdl/dme_pkg.sv
hdl/dme_decode.sv
hdl/dme_emit.sv
hdl/plotter_delta_move_encoder_unit.sv
test/tb_plotter_delta_move_encoder_unit.sv
